### src/rhd_pkg.sv
`timescale 1ns / 1ps

package rhd_pkg;

   localparam int MAX_CELLS = 32;
   localparam int LIMIT     = (MAX_CELLS < 32) ? MAX_CELLS : 32;
   localparam int ADDR_W    = $clog2(MAX_CELLS);
   localparam int CNT_W     = $clog2(LIMIT + 1);
   localparam int IDX_W     = 5;
   localparam int LEN_W     = 6;
   localparam int TEMP_W    = 24;
   localparam int K_W       = 16;
   // right + left - 2*mid needs two bits of growth plus sign margin
   localparam int DIFF_W    = TEMP_W + 3;
   localparam int PROD_W    = DIFF_W + K_W + 1;
   localparam int SH_W      = PROD_W - K_W;
   localparam int SUM_W     = SH_W + 1;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7FFFFF;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh800000;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SWEEP,
      SEQ_DRAIN
   } seq_state_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic [K_W-1:0]    cond;
      logic              fixed;
   } cell_type;

   typedef struct packed {
      logic              en;
      logic              full;   // load: write k and held flag too
      logic [ADDR_W-1:0] addr;
      cell_type          entry;
   } mem_wr_type;

   typedef struct packed {
      logic             advance;
      logic             tok_valid;
      logic [CNT_W-1:0] step;
      logic [CNT_W-1:0] len;
   } stn_ctl_type;

   typedef struct packed {
      logic              valid;
      logic              busy;
      logic [CNT_W-1:0]  idx;
      logic [TEMP_W-1:0] temp;
      logic              last;
   } stn_res_type;

endpackage

### src/rhd_cell_mem.sv
`timescale 1ns / 1ps

module rhd_cell_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  rhd_pkg::mem_wr_type           wr,
   input  logic                          rd_en,
   input  logic [rhd_pkg::ADDR_W-1:0]    rd_addr,
   output rhd_pkg::cell_type             rd_cell
);

   logic [rhd_pkg::TEMP_W-1:0] temp_mem [rhd_pkg::MAX_CELLS];
   logic [rhd_pkg::K_W-1:0]    cond_mem [rhd_pkg::MAX_CELLS];
   logic [rhd_pkg::MAX_CELLS-1:0] fixed_ff;
   rhd_pkg::cell_type             rd_cell_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         temp_mem[wr.addr] <= wr.entry.temp;
         if (wr.full) begin
            cond_mem[wr.addr] <= wr.entry.cond;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_ff <= '0;
      end else if (wr.en && wr.full) begin
         fixed_ff[wr.addr] <= wr.entry.fixed;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_cell_ff.temp  <= temp_mem[rd_addr];
         rd_cell_ff.cond  <= cond_mem[rd_addr];
         rd_cell_ff.fixed <= fixed_ff[rd_addr];
      end
   end

   assign rd_cell = rd_cell_ff;

endmodule

### src/rhd_stencil.sv
`timescale 1ns / 1ps

module rhd_stencil (
   input  logic                  clock,
   input  logic                  reset,
   input  rhd_pkg::stn_ctl_type  ctl,
   input  rhd_pkg::cell_type     rd_cell,
   output rhd_pkg::stn_res_type  res
);

   // window: left and middle cells; the freshly read cell is the right one
   logic signed [rhd_pkg::TEMP_W-1:0] lft_t_ff, mid_t_ff;
   logic [rhd_pkg::K_W-1:0]           mid_k_ff;
   logic                              mid_fix_ff;

   logic                              b_v_ff;
   logic [rhd_pkg::CNT_W-1:0]         b_idx_ff;
   logic signed [rhd_pkg::TEMP_W-1:0] b_t_ff;
   logic [rhd_pkg::K_W-1:0]           b_k_ff;
   logic                              b_fix_ff;
   logic                              b_last_ff;
   logic signed [rhd_pkg::DIFF_W-1:0] b_diff_ff;

   logic                              c_v_ff;
   logic [rhd_pkg::CNT_W-1:0]         c_idx_ff;
   logic signed [rhd_pkg::TEMP_W-1:0] c_t_ff;
   logic                              c_fix_ff;
   logic                              c_last_ff;
   logic signed [rhd_pkg::PROD_W-1:0] c_prod_ff;

   logic signed [rhd_pkg::DIFF_W-1:0] rgt_x, mid_x, lft_x, diff_in;
   logic signed [rhd_pkg::SH_W-1:0]   delta;
   logic signed [rhd_pkg::SUM_W-1:0]  sum;
   logic signed [rhd_pkg::TEMP_W-1:0] new_t;
   logic                              is_data, is_first, is_last;

   assign is_data  = ctl.step != ctl.len;
   assign is_first = ctl.step == rhd_pkg::CNT_W'(1);
   assign is_last  = ctl.step == ctl.len;

   always_comb begin
      rgt_x = rhd_pkg::DIFF_W'($signed(rd_cell.temp));
      mid_x = rhd_pkg::DIFF_W'(mid_t_ff);
      lft_x = rhd_pkg::DIFF_W'(lft_t_ff);
      if (is_first) begin
         diff_in = rgt_x - mid_x;
      end else if (is_last) begin
         diff_in = lft_x - mid_x;
      end else begin
         diff_in = rgt_x + lft_x - (mid_x <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (ctl.advance) begin
         b_v_ff <= ctl.tok_valid && (ctl.step != '0);
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         if (ctl.tok_valid && is_data) begin
            lft_t_ff   <= mid_t_ff;
            mid_t_ff   <= $signed(rd_cell.temp);
            mid_k_ff   <= rd_cell.cond;
            mid_fix_ff <= rd_cell.fixed;
         end
         b_idx_ff  <= ctl.step - rhd_pkg::CNT_W'(1);
         b_t_ff    <= mid_t_ff;
         b_k_ff    <= mid_k_ff;
         b_fix_ff  <= mid_fix_ff;
         b_last_ff <= is_last;
         b_diff_ff <= diff_in;
         c_idx_ff  <= b_idx_ff;
         c_t_ff    <= b_t_ff;
         c_fix_ff  <= b_fix_ff;
         c_last_ff <= b_last_ff;
         c_prod_ff <= rhd_pkg::PROD_W'(b_diff_ff * $signed({1'b0, b_k_ff}));
      end
   end

   // arithmetic shift by 16 floors the product back to Q16.8
   always_comb begin
      delta = c_prod_ff[rhd_pkg::PROD_W-1:rhd_pkg::K_W];
      sum   = rhd_pkg::SUM_W'(c_t_ff) + rhd_pkg::SUM_W'(delta);
      if (c_fix_ff) begin
         new_t = c_t_ff;
      end else if (sum > rhd_pkg::SUM_W'(rhd_pkg::TEMP_MAX)) begin
         new_t = rhd_pkg::TEMP_MAX;
      end else if (sum < rhd_pkg::SUM_W'(rhd_pkg::TEMP_MIN)) begin
         new_t = rhd_pkg::TEMP_MIN;
      end else begin
         new_t = sum[rhd_pkg::TEMP_W-1:0];
      end
   end

   assign res.valid = c_v_ff;
   assign res.busy  = b_v_ff || c_v_ff;
   assign res.idx   = c_idx_ff;
   assign res.temp  = new_t;
   assign res.last  = c_last_ff;

endmodule

### src/rod_heat_diffusion_step_unit.sv
`timescale 1ns / 1ps

// Rod heat-diffusion step unit. A load request writes one cell (temperature,
// k, held flag). A tick request sweeps the cell memory, one read per cycle
// unless rsp_stall holds it, through its single read port, and streams the new
// temperature of cells 0..rod_length-1 in order, last set on the final one.
// The sweep issues rod_length reads plus one flush step for the end cell;
// each result then passes the stencil, multiply and saturate steps and the
// response register. rsp_stall freezes the whole sweep. New values are
// written back behind the read front, so later cells still see old
// neighbors. Requests are stalled until the sweep has drained.
// rod_length is clamped to 2..32 on write.

module rod_heat_diffusion_step_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [4:0]                  req_cell_index,
   input  logic signed [23:0]          req_temperature,
   input  logic [15:0]                 req_conductance,
   input  logic                        req_held,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [4:0]                  rsp_out_index,
   output logic signed [23:0]          rsp_out_temperature,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [5:0]                  csr_wr_data
);

   rhd_pkg::seq_state_type          state_ff, state_in;
   logic [rhd_pkg::CNT_W-1:0]       len_ff, len_in;
   logic [rhd_pkg::CNT_W-1:0]       step_ff;
   logic                            tok_valid_ff;
   logic [rhd_pkg::CNT_W-1:0]       tok_step_ff;
   logic                            rsp_valid_ff;
   logic [rhd_pkg::IDX_W-1:0]       out_index_ff;
   logic signed [rhd_pkg::TEMP_W-1:0] out_temp_ff;
   logic                            out_last_ff;

   logic                            advance, accept, issue, rd_en, load_wr;
   rhd_pkg::mem_wr_type             mem_wr;
   rhd_pkg::cell_type               rd_cell;
   rhd_pkg::stn_ctl_type            stn_ctl;
   rhd_pkg::stn_res_type            stn_res;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign accept  = req_valid && !req_stall;
   assign load_wr = accept && (req_cmd == rhd_pkg::CMD_LOAD)
                    && (32'(req_cell_index) < rhd_pkg::MAX_CELLS);
   assign rd_en   = advance && issue && (step_ff != len_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rhd_pkg::SEQ_IDLE: begin
            if (accept && (req_cmd == rhd_pkg::CMD_TICK)) begin
               state_in = rhd_pkg::SEQ_SWEEP;
            end
         end
         rhd_pkg::SEQ_SWEEP: begin
            if (advance && (step_ff == len_ff)) begin
               state_in = rhd_pkg::SEQ_DRAIN;
            end
         end
         rhd_pkg::SEQ_DRAIN: begin
            if (!tok_valid_ff && !stn_res.busy) begin
               state_in = rhd_pkg::SEQ_IDLE;
            end
         end
         default: state_in = rhd_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      unique case (state_ff)
         rhd_pkg::SEQ_IDLE:  req_stall = 1'b0;
         rhd_pkg::SEQ_SWEEP: issue     = 1'b1;
         rhd_pkg::SEQ_DRAIN: issue     = 1'b0;
         default:            req_stall = 1'b1;
      endcase
   end

   always_comb begin
      if (csr_wr_data < 6'd2) begin
         len_in = rhd_pkg::CNT_W'(2);
      end else if (32'(csr_wr_data) > rhd_pkg::LIMIT) begin
         len_in = rhd_pkg::CNT_W'(rhd_pkg::LIMIT);
      end else begin
         len_in = rhd_pkg::CNT_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhd_pkg::SEQ_IDLE;
         len_ff       <= rhd_pkg::CNT_W'(2);
         step_ff      <= '0;
         tok_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            len_ff <= len_in;
         end
         if (accept) begin
            step_ff <= '0;
         end else if (advance && issue) begin
            step_ff <= step_ff + rhd_pkg::CNT_W'(1);
         end
         if (advance) begin
            tok_valid_ff <= issue;
            rsp_valid_ff <= stn_res.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_step_ff <= step_ff;
         if (stn_res.valid) begin
            out_index_ff <= rhd_pkg::IDX_W'(stn_res.idx);
            out_temp_ff  <= $signed(stn_res.temp);
            out_last_ff  <= stn_res.last;
         end
      end
   end

   always_comb begin
      if (load_wr) begin
         mem_wr.en          = 1'b1;
         mem_wr.full        = 1'b1;
         mem_wr.addr        = rhd_pkg::ADDR_W'(req_cell_index);
         mem_wr.entry.temp  = req_temperature;
         mem_wr.entry.cond  = req_conductance;
         mem_wr.entry.fixed = req_held;
      end else begin
         mem_wr.en          = advance && stn_res.valid;
         mem_wr.full        = 1'b0;
         mem_wr.addr        = rhd_pkg::ADDR_W'(stn_res.idx);
         mem_wr.entry.temp  = stn_res.temp;
         mem_wr.entry.cond  = '0;
         mem_wr.entry.fixed = 1'b0;
      end
   end

   assign stn_ctl.advance   = advance;
   assign stn_ctl.tok_valid = tok_valid_ff;
   assign stn_ctl.step      = tok_step_ff;
   assign stn_ctl.len       = len_ff;

   rhd_cell_mem u_cell_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rhd_pkg::ADDR_W'(step_ff)),
      .rd_cell (rd_cell)
   );

   rhd_stencil u_stencil (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stn_ctl),
      .rd_cell (rd_cell),
      .res     (stn_res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_index       = out_index_ff;
   assign rsp_out_temperature = out_temp_ff;
   assign rsp_last            = out_last_ff;

`ifndef SYNTHESIS
   // a new request only lands on an empty pipeline
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !tok_valid_ff && !stn_res.busy)
      else $error("request accepted with sweep in flight");

   // last marks the final cell of the run
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rhd_pkg::CNT_W'(rsp_out_index) == len_ff - rhd_pkg::CNT_W'(1))
      else $error("last on wrong cell");

   // load writes never collide with write-back
   a_wr_exclusive: assert property (@(posedge clock) disable iff (reset)
      load_wr |-> !stn_res.valid)
      else $error("load and write-back in same cycle");
`endif

endmodule
